// ===== sv/uepf_pkg.sv =====
// shared types and constants for the eulerian path finder
package uepf_pkg;

  // graph size, fixed by the 4-bit vertex ports
  localparam int MAX_VERTICES = 16;

  // result status codes
  localparam logic [1:0] ST_PATH   = 2'd0;
  localparam logic [1:0] ST_NOPATH = 2'd1;
  localparam logic [1:0] ST_ERROR  = 2'd2;

  // opcodes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_FIND = 1'b1;

  // controller states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD_RD,
    S_ADD_WR,
    S_ADD_MIRROR,
    S_SCAN,
    S_CHECK,
    S_WALK_RD,
    S_WALK_WAIT,
    S_WALK_SEARCH,
    S_WALK_UPD,
    S_WALK_MIRROR,
    S_VERIFY,
    S_EMIT,
    S_FAIL,
    S_GCLEAR
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic clr_init;
    logic clr_step;
    logic add_latch;
    logic add_rd;
    logic add_wr;
    logic add_mirror;
    logic scan_init;
    logic scan_step;
    logic walk_init;
    logic top_rd;
    logic row_rd;
    logic search_step;
    logic walk_upd;
    logic walk_mirror;
    logic emit_init;
    logic emit_step;
    logic fail_emit;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clr_done;
    logic add_bad;
    logic error_flag;
    logic scan_done;
    logic odd_ok;
    logic search_done;
    logic edge_found;
    logic stack_empty;
    logic path_ok;
    logic emit_done;
  } stat_t;

endpackage

// ===== sv/undirected_eulerian_path_finder_core.sv =====
// Eulerian path finder for small undirected multigraphs of up to 16 vertices. After
// reset a clearing pass sweeps the multiplicity memory before start is taken; each
// find also ends with that sweep. An add reads the entry, writes it and writes its
// mirror before busy falls; a dropped edge returns to idle after the read. A find
// runs a degree scan, then per walk step a stack read, a row read, a neighbour
// search through the memory port, an update and, when an edge is taken, a mirror
// write, for up to 2*MAX_EDGES+1 steps; then one path word per cycle is emitted
// (a single status word on a failure) and the clearing sweep runs. Results appear
// for one cycle with result_valid; the receiver cannot stall them.
module undirected_eulerian_path_finder_core #(
  parameter int MAX_EDGES = 63
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data,
  input  logic       start,
  output logic       busy,
  input  logic       opcode,
  input  logic [3:0] vertex_a,
  input  logic [3:0] vertex_b,
  output logic       result_valid,
  output logic [1:0] status,
  output logic [3:0] vertex,
  output logic       last
);

  logic [4:0] vertex_count;
  uepf_pkg::cmd_t cmd;
  uepf_pkg::stat_t stat;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) vertex_count <= 5'd16;
    else if (cfg_valid) vertex_count <= cfg_data;
  end

  uepf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .opcode(opcode),
    .busy(busy), .cmd(cmd), .stat(stat)
  );

  uepf_dp #(.MAX_EDGES(MAX_EDGES)) u_dp (
    .clk(clk), .rst(rst), .vertex_count(vertex_count),
    .vertex_a(vertex_a), .vertex_b(vertex_b), .cmd(cmd), .stat(stat),
    .result_valid(result_valid), .status(status), .vertex(vertex), .last(last)
  );

endmodule

// ===== sv/uepf_ctrl.sv =====
// controller state machine for the eulerian path finder
module uepf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             opcode,
  output logic             busy,
  output uepf_pkg::cmd_t   cmd,
  input  uepf_pkg::stat_t  stat
);

  uepf_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= uepf_pkg::S_CLEAR;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      uepf_pkg::S_CLEAR, uepf_pkg::S_GCLEAR: begin
        if (stat.clr_done) state_next = uepf_pkg::S_IDLE;
      end
      uepf_pkg::S_IDLE: begin
        if (start) begin
          if (opcode == uepf_pkg::OP_ADD) state_next = uepf_pkg::S_ADD_RD;
          else state_next = uepf_pkg::S_SCAN;
        end
      end
      uepf_pkg::S_ADD_RD: begin
        if (stat.add_bad) state_next = uepf_pkg::S_IDLE;
        else state_next = uepf_pkg::S_ADD_WR;
      end
      uepf_pkg::S_ADD_WR: state_next = uepf_pkg::S_ADD_MIRROR;
      uepf_pkg::S_ADD_MIRROR: state_next = uepf_pkg::S_IDLE;
      uepf_pkg::S_SCAN: begin
        if (stat.error_flag) state_next = uepf_pkg::S_FAIL;
        else if (stat.scan_done) state_next = uepf_pkg::S_CHECK;
      end
      uepf_pkg::S_CHECK: begin
        if (stat.odd_ok) state_next = uepf_pkg::S_WALK_RD;
        else state_next = uepf_pkg::S_FAIL;
      end
      uepf_pkg::S_WALK_RD: begin
        if (stat.stack_empty) state_next = uepf_pkg::S_VERIFY;
        else state_next = uepf_pkg::S_WALK_WAIT;
      end
      uepf_pkg::S_WALK_WAIT: state_next = uepf_pkg::S_WALK_SEARCH;
      uepf_pkg::S_WALK_SEARCH: begin
        if (stat.search_done) state_next = uepf_pkg::S_WALK_UPD;
      end
      uepf_pkg::S_WALK_UPD: begin
        if (stat.edge_found) state_next = uepf_pkg::S_WALK_MIRROR;
        else state_next = uepf_pkg::S_WALK_RD;
      end
      uepf_pkg::S_WALK_MIRROR: state_next = uepf_pkg::S_WALK_RD;
      uepf_pkg::S_VERIFY: begin
        if (stat.path_ok) state_next = uepf_pkg::S_EMIT;
        else state_next = uepf_pkg::S_FAIL;
      end
      uepf_pkg::S_EMIT: begin
        if (stat.emit_done) state_next = uepf_pkg::S_GCLEAR;
      end
      uepf_pkg::S_FAIL: state_next = uepf_pkg::S_GCLEAR;
      default: state_next = uepf_pkg::S_CLEAR;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    busy = (state != uepf_pkg::S_IDLE);
    case (state)
      uepf_pkg::S_CLEAR, uepf_pkg::S_GCLEAR: cmd.clr_step = 1'b1;
      uepf_pkg::S_IDLE: begin
        if (start) begin
          cmd.add_latch = 1'b1;
          cmd.scan_init = 1'b1;
        end
      end
      uepf_pkg::S_ADD_RD: cmd.add_rd = 1'b1;
      uepf_pkg::S_ADD_WR: cmd.add_wr = 1'b1;
      uepf_pkg::S_ADD_MIRROR: cmd.add_mirror = 1'b1;
      uepf_pkg::S_SCAN: cmd.scan_step = 1'b1;
      uepf_pkg::S_CHECK: cmd.walk_init = 1'b1;
      uepf_pkg::S_WALK_RD: cmd.top_rd = 1'b1;
      uepf_pkg::S_WALK_WAIT: cmd.row_rd = 1'b1;
      uepf_pkg::S_WALK_SEARCH: cmd.search_step = 1'b1;
      uepf_pkg::S_WALK_UPD: cmd.walk_upd = 1'b1;
      uepf_pkg::S_WALK_MIRROR: cmd.walk_mirror = 1'b1;
      uepf_pkg::S_VERIFY: cmd.emit_init = 1'b1;
      uepf_pkg::S_EMIT: begin
        cmd.emit_step = 1'b1;
        if (stat.emit_done) cmd.clr_init = 1'b1;
      end
      uepf_pkg::S_FAIL: begin
        cmd.fail_emit = 1'b1;
        cmd.clr_init = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== sv/uepf_dp.sv =====
// datapath: multiplicity memory, degrees, walk stack, path store and result register
module uepf_dp #(
  parameter int MAX_EDGES = 63
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [4:0]       vertex_count,
  input  logic [3:0]       vertex_a,
  input  logic [3:0]       vertex_b,
  input  uepf_pkg::cmd_t   cmd,
  output uepf_pkg::stat_t  stat,
  output logic             result_valid,
  output logic [1:0]       status,
  output logic [3:0]       vertex,
  output logic             last
);

  localparam int NV = uepf_pkg::MAX_VERTICES;
  localparam int VW = 4;
  localparam int VCW = $clog2(NV + 1);
  localparam int AW = 2 * VW;
  localparam int DEPTH = NV * NV;
  localparam int SD = 64;

  // multiplicity memory, one read and one write port
  logic [6:0] mult_mem [DEPTH];
  logic [6:0] mult_rd;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [6:0] wr_data;
  logic wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) mult_mem[wr_addr] <= wr_data;
    mult_rd <= mult_mem[rd_addr];
  end

  // walk stack and path store
  logic [VW-1:0] stack_mem [SD];
  logic [VW-1:0] path_mem [SD];
  logic [6:0] sp;
  logic [6:0] plen;
  logic [VW-1:0] top_v;

  logic [6:0] degree [NV];
  logic [5:0] edge_total;
  logic error_flag;

  // effective vertex count
  logic [VCW-1:0] n_eff;
  always_comb begin
    if (vertex_count == 5'd0) n_eff = VCW'(1);
    else if ({27'd0, vertex_count} > 32'(NV)) n_eff = VCW'(NV);
    else n_eff = VCW'(vertex_count);
  end

  // latched operands, counters
  logic [VW-1:0] va, vb;
  logic [AW:0] clr_cnt;
  logic [VCW-1:0] idx;
  logic [1:0] odd_cnt;
  logic odd_many;
  logic [VW-1:0] start_v;
  logic [VW-1:0] nb;
  logic found;
  logic [6:0] emit_idx;
  logic add_bad;
  logic [6:0] add_inc;
  logic [6:0] upd_val;

  assign add_bad = ({1'b0, va} >= n_eff) || ({1'b0, vb} >= n_eff)
                   || ({26'd0, edge_total} >= 32'(MAX_EDGES));

  // a self-loop puts both edge ends on the diagonal
  assign add_inc = (va == vb) ? 7'd2 : 7'd1;
  assign upd_val = mult_rd - ((top_v == nb) ? 7'd2 : 7'd1);

  // memory address selection; the table is symmetric, so the mirror entry
  // takes the same value that is written to the entry read
  always_comb begin
    rd_addr = {va, vb};
    wr_addr = {va, vb};
    wr_data = mult_rd + add_inc;
    wr_en = 1'b0;
    if (cmd.clr_step) begin
      wr_addr = clr_cnt[AW-1:0];
      wr_data = '0;
      wr_en = 1'b1;
    end else if (cmd.add_wr) begin
      wr_en = 1'b1;
    end else if (cmd.add_mirror) begin
      wr_en = 1'b1;
      wr_addr = {vb, va};
    end else if (cmd.row_rd) begin
      rd_addr = {top_v, idx[VW-1:0]};
    end else if (cmd.search_step) begin
      if (found) rd_addr = {top_v, nb};
      else rd_addr = {top_v, idx[VW-1:0] + VW'(1)};
    end else if (cmd.walk_upd) begin
      rd_addr = {top_v, nb};
      wr_addr = {top_v, nb};
      wr_data = upd_val;
      wr_en = found;
    end else if (cmd.walk_mirror) begin
      wr_addr = {nb, top_v};
      wr_data = upd_val;
      wr_en = 1'b1;
    end
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      edge_total <= '0;
      error_flag <= 1'b0;
      result_valid <= 1'b0;
      sp <= '0;
      plen <= '0;
      for (int i = 0; i < NV; i++) degree[i] <= '0;
    end else begin
      result_valid <= cmd.emit_step | cmd.fail_emit;
      if (cmd.clr_init) clr_cnt <= '0;
      if (cmd.clr_step) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.add_latch) begin
        va <= vertex_a;
        vb <= vertex_b;
      end
      // add edge: degrees and count
      if (cmd.add_rd) begin
        if (add_bad) error_flag <= 1'b1;
        else begin
          if (va == vb) degree[va] <= degree[va] + 7'd2;
          else begin
            degree[va] <= degree[va] + 7'd1;
            degree[vb] <= degree[vb] + 7'd1;
          end
          edge_total <= edge_total + 6'd1;
        end
      end
      // degree scan
      if (cmd.scan_init) begin
        idx <= '0;
        odd_cnt <= '0;
        odd_many <= 1'b0;
        start_v <= '0;
      end
      if (cmd.scan_step && idx < n_eff) begin
        if (degree[idx[VW-1:0]][0]) begin
          if (odd_cnt == 2'd2) odd_many <= 1'b1;
          else odd_cnt <= odd_cnt + 2'd1;
          start_v <= idx[VW-1:0];
        end
        idx <= idx + 1'b1;
      end
      // walk start
      if (cmd.walk_init) begin
        stack_mem[0] <= start_v;
        sp <= 7'd1;
        plen <= '0;
      end
      // read stack top
      if (cmd.top_rd) begin
        top_v <= stack_mem[sp[5:0] - 6'd1];
        idx <= '0;
        found <= 1'b0;
      end
      // smallest neighbour search, one entry per cycle
      if (cmd.search_step) begin
        if (!found && idx < n_eff) begin
          if (mult_rd != '0) begin
            found <= 1'b1;
            nb <= idx[VW-1:0];
          end else idx <= idx + 1'b1;
        end
      end
      if (cmd.walk_upd) begin
        if (found) begin
          if (sp < 7'(SD)) begin
            stack_mem[sp[5:0]] <= nb;
            sp <= sp + 7'd1;
          end
        end else begin
          sp <= sp - 7'd1;
          if (plen < 7'(SD)) path_mem[plen[5:0]] <= top_v;
          plen <= plen + 7'd1;
        end
      end
      // result output
      if (cmd.emit_init) emit_idx <= '0;
      if (cmd.emit_step) begin
        status <= uepf_pkg::ST_PATH;
        vertex <= 4'(path_mem[emit_idx[5:0]]);
        last <= (emit_idx + 7'd1 == plen);
        emit_idx <= emit_idx + 7'd1;
      end
      if (cmd.fail_emit) begin
        status <= error_flag ? uepf_pkg::ST_ERROR : uepf_pkg::ST_NOPATH;
        vertex <= '0;
        last <= 1'b1;
      end
      if (cmd.clr_init) begin
        edge_total <= '0;
        error_flag <= 1'b0;
        for (int i = 0; i < NV; i++) degree[i] <= '0;
      end
    end
  end

  // status back to controller
  always_comb begin
    stat.clr_done = (clr_cnt == (AW+1)'(DEPTH - 1));
    stat.add_bad = add_bad;
    stat.error_flag = error_flag;
    stat.scan_done = (idx >= n_eff);
    stat.odd_ok = !odd_many && (odd_cnt != 2'd1);
    stat.search_done = found || (idx >= n_eff);
    stat.edge_found = found;
    stat.stack_empty = (sp == 7'd0);
    stat.path_ok = (plen == {1'b0, edge_total} + 7'd1);
    stat.emit_done = (emit_idx + 7'd1 == plen);
  end

endmodule

// ===== tb/undirected_eulerian_path_finder_core_tb.sv =====
// self-checking testbench for the undirected eulerian path finder core
`timescale 1ns / 100ps

module undirected_eulerian_path_finder_core_tb;

  localparam int NUM_VERTS = 16;
  localparam int EDGE_LIMIT = 63;
  localparam int SETTLE_CYCLES = 300;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [1:0] st;
    logic [3:0] vx;
    logic       lst;
  } path_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [4:0] cfg_data = '0;
  logic       start = 1'b0;
  logic       busy;
  logic       opcode = uepf_pkg::OP_ADD;
  logic [3:0] vertex_a = '0;
  logic [3:0] vertex_b = '0;
  logic       result_valid;
  logic [1:0] status;
  logic [3:0] vertex;
  logic       last;

  // predictor state
  logic [6:0] mult_tab [NUM_VERTS][NUM_VERTS];
  logic [6:0] degree_tab [NUM_VERTS];
  int         edge_count;
  logic       graph_bad;
  logic [4:0] vcount_reg;

  path_word_t expected_words[$];
  int         fail_count = 0;
  int         cycle_count = 0;
  bit         steady_send = 1'b0;

  undirected_eulerian_path_finder_core uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .start(start), .busy(busy),
    .opcode(opcode), .vertex_a(vertex_a), .vertex_b(vertex_b),
    .result_valid(result_valid), .status(status), .vertex(vertex), .last(last)
  );

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    fail_count++;
  endtask

  // result word checker
  always @(posedge clk) begin
    path_word_t exp_w;
    if (!rst && result_valid) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word st=%0d v=%0d l=%0d", status, vertex, last));
      end else begin
        exp_w = expected_words.pop_front();
        if (status !== exp_w.st)
          report_mismatch($sformatf("status %0d, wanted %0d", status, exp_w.st));
        if (vertex !== exp_w.vx)
          report_mismatch($sformatf("vertex %0d, wanted %0d", vertex, exp_w.vx));
        if (last !== exp_w.lst)
          report_mismatch($sformatf("last %0d, wanted %0d", last, exp_w.lst));
      end
    end
  end

  function automatic int active_verts();
    if (vcount_reg < 1) return 1;
    if (vcount_reg > NUM_VERTS) return NUM_VERTS;
    return vcount_reg;
  endfunction

  function automatic void wipe_graph();
    foreach (mult_tab[i, j]) mult_tab[i][j] = '0;
    foreach (degree_tab[i]) degree_tab[i] = '0;
    edge_count = 0;
    graph_bad = 1'b0;
  endfunction

  function automatic void push_word(input logic [1:0] st, input logic [3:0] vx,
                                    input logic lst);
    path_word_t w;
    w.st = st;
    w.vx = vx;
    w.lst = lst;
    expected_words = {expected_words, w};
  endfunction

  // hierholzer walk on the predictor graph, queues the expected words
  function automatic void trace_euler_path();
    int n, odd, first, sp, plen, cur, nxt;
    logic [3:0] stk [64];
    logic [3:0] path [64];
    n = active_verts();
    odd = 0;
    first = 0;
    sp = 0;
    plen = 0;
    for (int i = 0; i < n; i++)
      if (degree_tab[i][0]) begin
        odd++;
        first = i;
      end
    if (odd != 0 && odd != 2) begin
      push_word(uepf_pkg::ST_NOPATH, 4'd0, 1'b1);
      return;
    end
    stk[0] = first[3:0];
    sp = 1;
    while (sp > 0) begin
      cur = stk[sp-1];
      nxt = n;
      for (int i = 0; i < n; i++)
        if (mult_tab[cur][i] != 0) begin
          nxt = i;
          break;
        end
      if (nxt < n) begin
        mult_tab[cur][nxt]--;
        mult_tab[nxt][cur]--;
        if (sp < 64) begin
          stk[sp] = nxt[3:0];
          sp++;
        end
      end else begin
        sp--;
        if (plen < 64) path[plen] = cur[3:0];
        plen++;
      end
    end
    if (plen != edge_count + 1 || plen > 64) begin
      push_word(uepf_pkg::ST_NOPATH, 4'd0, 1'b1);
      return;
    end
    for (int i = 0; i < plen; i++)
      push_word(uepf_pkg::ST_PATH, path[i], (i + 1 == plen));
  endfunction

  function automatic void predict_command(input logic op, input logic [3:0] a,
                                          input logic [3:0] b);
    int n;
    n = active_verts();
    if (op == uepf_pkg::OP_ADD) begin
      if (a >= n || b >= n || edge_count >= EDGE_LIMIT) begin
        graph_bad = 1'b1;
      end else begin
        mult_tab[a][b]++;
        mult_tab[b][a]++;
        degree_tab[a]++;
        degree_tab[b]++;
        edge_count++;
      end
    end else begin
      if (graph_bad) push_word(uepf_pkg::ST_ERROR, 4'd0, 1'b1);
      else trace_euler_path();
      wipe_graph();
    end
  endfunction

  // send one command word; called at a rising edge
  task automatic send_word(input logic op, input logic [3:0] a, input logic [3:0] b);
    if (!steady_send && $urandom_range(0, 99) < 38) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    vertex_a <= a;
    vertex_b <= b;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    predict_command(op, a, b);
  endtask

  task automatic drain_words();
    start <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0 || busy) @(posedge clk);
  endtask

  // register write while the block is idle
  task automatic write_vcount(input logic [4:0] val);
    drain_words();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    vcount_reg = val;
  endtask

  task automatic send_find();
    send_word(uepf_pkg::OP_FIND, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
  endtask

  // random trail over the active vertices plus noise_pct% random edges
  task automatic send_trail(input int edges, input int noise_pct);
    int n, cur, nxt;
    n = active_verts();
    cur = $urandom_range(0, n - 1);
    for (int k = 0; k < edges; k++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_word(uepf_pkg::OP_ADD, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      end else begin
        nxt = $urandom_range(0, n - 1);
        if ($urandom_range(0, 1)) send_word(uepf_pkg::OP_ADD, cur[3:0], nxt[3:0]);
        else send_word(uepf_pkg::OP_ADD, nxt[3:0], cur[3:0]);
        cur = nxt;
      end
    end
  endtask

  task automatic test_directed();
    // empty graph
    send_find();
    // extremes, repeat edge and self-loop
    send_word(uepf_pkg::OP_ADD, 4'd0, 4'd15);
    send_word(uepf_pkg::OP_ADD, 4'd15, 4'd15);
    send_word(uepf_pkg::OP_ADD, 4'd15, 4'd0);
    send_word(uepf_pkg::OP_ADD, 4'd0, 4'd7);
    send_find();
    // four odd vertices
    send_word(uepf_pkg::OP_ADD, 4'd1, 4'd2);
    send_word(uepf_pkg::OP_ADD, 4'd3, 4'd4);
    send_find();
    // disconnected cycles, walk misses edges
    send_word(uepf_pkg::OP_ADD, 4'd5, 4'd5);
    send_word(uepf_pkg::OP_ADD, 4'd9, 4'd10);
    send_word(uepf_pkg::OP_ADD, 4'd10, 4'd9);
    send_find();
  endtask

  task automatic test_bad_vertex();
    write_vcount(5'd4);
    send_word(uepf_pkg::OP_ADD, 4'd1, 4'd3);
    send_word(uepf_pkg::OP_ADD, 4'd4, 4'd0);
    send_find();
    send_word(uepf_pkg::OP_ADD, 4'd2, 4'd3);
    send_word(uepf_pkg::OP_ADD, 4'd3, 4'd2);
    send_find();
  endtask

  task automatic test_edge_overflow();
    write_vcount(5'd16);
    steady_send = 1'b1;
    send_trail(63, 0);
    steady_send = 1'b0;
    send_find();
    send_trail(64, 0);
    send_find();
  endtask

  task automatic test_count_extremes();
    write_vcount(5'd0);
    send_word(uepf_pkg::OP_ADD, 4'd0, 4'd0);
    send_find();
    send_word(uepf_pkg::OP_ADD, 4'd0, 4'd1);
    send_find();
    write_vcount(5'd31);
    send_trail(6, 0);
    send_find();
    write_vcount(5'd1);
    send_word(uepf_pkg::OP_ADD, 4'd0, 4'd0);
    send_find();
  endtask

  task automatic test_shrunk_count();
    write_vcount(5'd16);
    send_word(uepf_pkg::OP_ADD, 4'd0, 4'd1);
    send_word(uepf_pkg::OP_ADD, 4'd12, 4'd13);
    send_word(uepf_pkg::OP_ADD, 4'd13, 4'd12);
    write_vcount(5'd4);
    send_find();
  endtask

  task automatic test_random_trails();
    logic [4:0] counts [6] = '{5'd16, 5'd2, 5'd9, 5'd16, 5'd10, 5'd16};
    foreach (counts[p]) begin
      write_vcount(counts[p]);
      steady_send = (p == 3);
      repeat (2) begin
        send_trail($urandom_range(0, 8), 8);
        if ($urandom_range(0, 3) == 0) drain_words();
        send_find();
      end
    end
    steady_send = 1'b0;
  endtask

  initial begin
    wipe_graph();
    vcount_reg = 5'd16;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_bad_vertex();
    test_edge_overflow();
    test_count_extremes();
    test_shrunk_count();
    test_random_trails();
    drain_words();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/uepf_pkg.sv
sv/uepf_ctrl.sv
sv/uepf_dp.sv
sv/undirected_eulerian_path_finder_core.sv
tb/undirected_eulerian_path_finder_core_tb.sv
